@@ rtl/krt_pkg.sv @@
`timescale 1ns / 1ps
package krt_pkg;

   localparam int TableDepthDefault = 64;
   localparam int IdW = 32;
   localparam int CatW = 2;
   localparam int IndexW = 6;
   localparam int TotalW = 7;

   typedef enum logic [2:0] {
      ACT_ADD    = 3'd0,
      ACT_FIND   = 3'd1,
      ACT_MODIFY = 3'd2,
      ACT_DELETE = 3'd3,
      ACT_SORT   = 3'd4,
      ACT_CLEAR  = 3'd5,
      ACT_RSVD6  = 3'd6,
      ACT_RSVD7  = 3'd7
   } action_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_NOT_FOUND = 3'd1,
      ST_EMPTY     = 3'd2,
      ST_DUPLICATE = 3'd3,
      ST_FULL      = 3'd4,
      ST_BAD_CAT   = 3'd5
   } status_type;

   typedef struct packed {
      action_type             action;
      logic signed [IdW-1:0]  key_id;
      logic signed [IdW-1:0]  new_id;
      logic [CatW-1:0]        category;
   } req_type;

   typedef struct packed {
      status_type             status;
      logic [IndexW-1:0]      entry_index;
      logic signed [IdW-1:0]  entry_id;
      logic [CatW-1:0]        entry_category;
      logic [TotalW-1:0]      entry_total;
   } rsp_type;

endpackage

@@ rtl/keyed_record_table.sv @@
`timescale 1ns / 1ps
// Keyed record table: holds up to TABLE_DEPTH records of a unique signed id and a
// category, in one single-port-write, single-port-read memory. One request is taken
// at a time; req_stall stays high until its response has been taken. Each memory
// access has an address step, then a registered data step. A find, add or modify
// scans every stored record, a delete adds a compaction that moves each later
// record down one place, and the sort is a bubble sort of adjacent compares.
// Clear and reserved actions go straight to the response.
// The memory read port is shared by the scan, compaction, sort and show steps; only the sort uses id_gt.
module keyed_record_table
   import krt_pkg::*;
#(
   parameter int TABLE_DEPTH = TableDepthDefault
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam logic [CW-1:0] DepthC = CW'(TABLE_DEPTH);

   typedef enum logic [3:0] {
      S_IDLE, S_SCAN_A, S_SCAN_W, S_SCAN_C, S_DECIDE, S_DEL_A, S_DEL_W,
      S_SORT_A, S_SORT_B, S_SORT_C, S_SORT_W, S_SHOW_A, S_SHOW_W, S_RESP
   } state_type;

   state_type state_ff;
   req_type   req_ff;
   rsp_type   rsp_ff;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] ptr_ff;      // scan / walk pointer
   logic [CW-1:0] limit_ff;    // sort pass limit
   logic [CW-1:0] key_pos_ff;
   logic          key_hit_ff;
   logic          nid_hit_ff;
   logic [IdW+CatW-1:0] hold_ff; // record held for sort swap
   logic [CW-1:0] show_ff;

   logic                wr_en;
   logic [AW-1:0]       wr_addr, rd_addr;
   logic [IdW+CatW-1:0] wr_data, rd_data;

   krt_store #(.TABLE_DEPTH(TABLE_DEPTH)) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // id comparator for the sort
   logic signed [IdW-1:0] rd_id, hold_id;
   logic                  id_gt;
   assign rd_id   = rd_data[IdW+CatW-1:CatW];
   assign hold_id = hold_ff[IdW+CatW-1:CatW];
   assign id_gt   = hold_id > rd_id;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);
   assign rsp_data  = rsp_ff;

   // memory port control
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = ptr_ff[AW-1:0];
      wr_data = rd_data;
      rd_addr = ptr_ff[AW-1:0];
      case (state_ff)
         S_DECIDE: begin
            wr_data = {req_ff.action == ACT_ADD ? req_ff.key_id : req_ff.new_id,
                       req_ff.category};
            if (req_ff.action == ACT_ADD) begin
               wr_addr = count_ff[AW-1:0];
               wr_en = !key_hit_ff && count_ff < DepthC && req_ff.category != '0;
            end else begin
               wr_addr = key_pos_ff[AW-1:0];
               wr_en = req_ff.action == ACT_MODIFY && count_ff != '0 && key_hit_ff
                       && !nid_hit_ff && req_ff.category != '0;
            end
         end
         S_DEL_W: begin
            // move record at ptr down one place
            wr_en   = 1'b1;
            wr_addr = AW'(ptr_ff - 1'b1);
         end
         S_SORT_C: begin
            // on a swap, write the smaller at j here, then the larger at j+1 in S_SORT_W
            wr_en   = id_gt;
            wr_addr = AW'(ptr_ff - 1'b1);
            wr_data = rd_data;
         end
         S_SORT_W: begin
            wr_en   = 1'b1;
            wr_data = hold_ff;
         end
         S_SHOW_A: rd_addr = show_ff[AW-1:0];
         default: ;
      endcase
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  req_ff     <= req_data;
                  ptr_ff     <= (req_data.action == ACT_SORT) ? CW'(1) : '0;
                  key_hit_ff <= 1'b0;
                  nid_hit_ff <= 1'b0;
                  key_pos_ff <= '0;
                  rsp_ff     <= '{status: ST_OK, entry_index: '0, entry_id: '0,
                                  entry_category: '0,
                                  entry_total: (req_data.action == ACT_CLEAR) ?
                                               '0 : TotalW'(count_ff)};
                  case (req_data.action)
                     ACT_ADD, ACT_FIND, ACT_MODIFY, ACT_DELETE: state_ff <= S_SCAN_A;
                     ACT_SORT: begin
                        limit_ff <= count_ff;
                        state_ff <= S_SORT_A;
                     end
                     ACT_CLEAR: begin
                        count_ff <= '0;
                        state_ff <= S_RESP;
                     end
                     default: state_ff <= S_RESP;
                  endcase
               end
            end
            // linear search for key_id and new_id
            S_SCAN_A: begin
               state_ff <= (ptr_ff < count_ff) ? S_SCAN_W : S_DECIDE;
            end
            S_SCAN_W: state_ff <= S_SCAN_C;
            S_SCAN_C: begin
               if (rd_id == req_ff.key_id && !key_hit_ff) begin
                  key_hit_ff <= 1'b1;
                  key_pos_ff <= ptr_ff;
               end
               if (rd_id == req_ff.new_id) nid_hit_ff <= 1'b1;
               ptr_ff   <= ptr_ff + 1'b1;
               state_ff <= S_SCAN_A;
            end
            S_DECIDE: begin
               case (req_ff.action)
                  ACT_ADD: begin
                     state_ff <= S_RESP;
                     if (key_hit_ff) rsp_ff.status <= ST_DUPLICATE;
                     else if (count_ff >= DepthC) rsp_ff.status <= ST_FULL;
                     else if (req_ff.category == '0) rsp_ff.status <= ST_BAD_CAT;
                     else begin
                        count_ff <= count_ff + 1'b1;
                        rsp_ff.entry_total    <= TotalW'(count_ff + 1'b1);
                        rsp_ff.entry_index    <= IndexW'(count_ff);
                        rsp_ff.entry_id       <= req_ff.key_id;
                        rsp_ff.entry_category <= req_ff.category;
                     end
                  end
                  default: begin
                     if (count_ff == '0) begin
                        rsp_ff.status <= ST_EMPTY;
                        state_ff <= S_RESP;
                     end else if (!key_hit_ff) begin
                        rsp_ff.status <= ST_NOT_FOUND;
                        state_ff <= S_RESP;
                     end else if (req_ff.action == ACT_FIND) begin
                        show_ff  <= key_pos_ff;
                        state_ff <= S_SHOW_A;
                     end else if (req_ff.action == ACT_MODIFY) begin
                        state_ff <= S_RESP;
                        if (nid_hit_ff) rsp_ff.status <= ST_DUPLICATE;
                        else if (req_ff.category == '0) rsp_ff.status <= ST_BAD_CAT;
                        else begin
                           rsp_ff.entry_index    <= IndexW'(key_pos_ff);
                           rsp_ff.entry_id       <= req_ff.new_id;
                           rsp_ff.entry_category <= req_ff.category;
                        end
                     end else begin
                        ptr_ff   <= key_pos_ff + 1'b1;
                        state_ff <= S_DEL_A;
                     end
                  end
               endcase
            end
            // compaction after delete
            S_DEL_A: begin
               if (ptr_ff < count_ff) state_ff <= S_DEL_W;
               else begin
                  count_ff <= count_ff - 1'b1;
                  rsp_ff.entry_total <= TotalW'(count_ff - 1'b1);
                  if (key_pos_ff < count_ff - 1'b1) begin
                     show_ff  <= key_pos_ff;
                     state_ff <= S_SHOW_A;
                  end else begin
                     rsp_ff.entry_index <= IndexW'(key_pos_ff);
                     state_ff <= S_RESP;
                  end
               end
            end
            S_DEL_W: begin
               ptr_ff   <= ptr_ff + 1'b1;
               state_ff <= S_DEL_A;
            end
            // bubble sort: ptr is j+1, hold is record j
            S_SORT_A: begin
               if (limit_ff < CW'(2)) begin
                  rsp_ff.entry_total <= TotalW'(count_ff);
                  if (count_ff != '0) begin
                     show_ff  <= '0;
                     state_ff <= S_SHOW_A;
                  end else state_ff <= S_RESP;
               end else if (ptr_ff >= limit_ff) begin
                  limit_ff <= limit_ff - 1'b1;
                  ptr_ff   <= CW'(1);
               end else if (ptr_ff == CW'(1)) begin
                  ptr_ff   <= '0;
                  state_ff <= S_SORT_B;
               end else state_ff <= S_SORT_B;
            end
            S_SORT_B: begin
               // a new pass reads record 0 first, then loads it into hold
               if (ptr_ff == '0) begin
                  ptr_ff <= CW'(1);
               end else begin
                  if (ptr_ff == CW'(1)) hold_ff <= rd_data;
                  state_ff <= S_SORT_C;
               end
            end
            S_SORT_C: begin
               if (id_gt) state_ff <= S_SORT_W;
               else begin
                  hold_ff  <= rd_data;
                  ptr_ff   <= ptr_ff + 1'b1;
                  state_ff <= S_SORT_A;
               end
            end
            S_SORT_W: begin
               ptr_ff   <= ptr_ff + 1'b1;
               state_ff <= S_SORT_A;
            end
            S_SHOW_A: state_ff <= S_SHOW_W;
            S_SHOW_W: begin
               rsp_ff.entry_index    <= IndexW'(show_ff);
               rsp_ff.entry_id       <= rd_id;
               rsp_ff.entry_category <= rd_data[CatW-1:0];
               state_ff <= S_RESP;
            end
            S_RESP: if (!rsp_stall) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef NO_ASSERTIONS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DepthC) else $error("record count above depth");
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("request taken while response pending");
   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && req_valid && req_data.action == ACT_CLEAR)
      |=> count_ff == '0) else $error("clear left records");
`endif

endmodule

@@ rtl/krt_store.sv @@
`timescale 1ns / 1ps
// record memory: one write port, one registered read port
module krt_store
   import krt_pkg::*;
#(
   parameter int TABLE_DEPTH = TableDepthDefault,
   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
   input  logic                   clock,
   input  logic                   wr_en,
   input  logic [AW-1:0]          wr_addr,
   input  logic [IdW+CatW-1:0]    wr_data,
   input  logic [AW-1:0]          rd_addr,
   output logic [IdW+CatW-1:0]    rd_data
);

   logic [IdW+CatW-1:0] mem [TABLE_DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule
